// ===== src/bpm_pkg.sv =====
// Shared types, constants and helpers for the byte pattern matcher.
package bpm_pkg;

  // Default window depth; the pattern registers always hold sixteen bytes.
  localparam int unsigned MAX_PATTERN_BYTES_DEF = 16;
  localparam int unsigned PATTERN_REG_BYTES     = 16;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_CFG_W  = 5;
  localparam int unsigned OFFSET_W   = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  typedef logic [7:0] byte_t;

  // Per-cycle control handed to every cell of the window.
  typedef struct packed {
    logic shift;
    logic clear;
  } bpm_cell_ctl_t;

  // Pick pattern byte idx out of the packed sixteen-byte pattern.
  function automatic byte_t pat_byte(input logic [8*PATTERN_REG_BYTES-1:0] pat,
                                     input logic [3:0] idx);
    pat_byte = pat[{idx, 3'b000} +: 8];
  endfunction

endpackage

// ===== src/byte_pattern_matcher.sv =====
// Top level of the byte pattern matcher: cell chain, offset counter, output skid stage.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+--------------------------------
//  in_     | input     | in_valid / in_stall   | data_byte, last_of_file
//  out_    | output    | out_valid / out_stall | found, start_offset
//  cfg_    | input     | cfg_wr_en             | cfg_index, cfg_wdata
//
// One byte is taken every cycle while in_stall is low; the compare across all cells
// and the offset subtract settle in the same cycle, and the result is then registered.
// A two-entry output stage (output register plus skid) lets input run while a
// result waits; in_stall rises only when both entries are full.
// Reset clears the cell fill flags, counters and pattern registers (length 1).
module byte_pattern_matcher #(
  parameter int unsigned MAX_PATTERN_BYTES = bpm_pkg::MAX_PATTERN_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last_of_file,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_found,
  output logic [bpm_pkg::OFFSET_W-1:0]   out_start_offset,
  input  logic                           cfg_wr_en,
  input  logic [bpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int unsigned OW    = bpm_pkg::OFFSET_W;

  // Configuration registers
  logic [63:0]                   pat_low_r, pat_low_nxt;
  logic [63:0]                   pat_high_r, pat_high_nxt;
  logic [bpm_pkg::LEN_CFG_W-1:0] pat_len_r, pat_len_nxt;

  always_comb begin
    pat_low_nxt  = pat_low_r;
    pat_high_nxt = pat_high_r;
    pat_len_nxt  = pat_len_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        bpm_pkg::REG_PATTERN_LOW:    pat_low_nxt  = cfg_wdata[63:0];
        bpm_pkg::REG_PATTERN_HIGH:   pat_high_nxt = cfg_wdata[63:0];
        bpm_pkg::REG_PATTERN_LENGTH: pat_len_nxt  = cfg_wdata[bpm_pkg::LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= bpm_pkg::LEN_CFG_W'(1);
    end else begin
      pat_low_r  <= pat_low_nxt;
      pat_high_r <= pat_high_nxt;
      pat_len_r  <= pat_len_nxt;
    end
  end

  // Clamp the programmed length to 1 .. MAX_PATTERN_BYTES
  logic [LEN_W-1:0] len;
  always_comb begin
    if (pat_len_r == '0) begin
      len = LEN_W'(1);
    end else if (32'(pat_len_r) > 32'(MAX_PATTERN_BYTES)) begin
      len = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len = LEN_W'(pat_len_r);
    end
  end

  // Handshake and scan control
  logic        accept, scan, hit, restart, result;
  logic        match_done_r, match_done_nxt;
  logic [OW-1:0] byte_offset_r, byte_offset_nxt;
  bpm_pkg::bpm_cell_ctl_t ctl;

  assign accept  = in_valid && !in_stall;
  assign scan    = accept && !match_done_r;
  assign restart = accept && in_last_of_file;
  assign ctl.shift = scan;
  assign ctl.clear = restart;

  // Cell chain: cell i sees the byte that will sit at window position i
  bpm_pkg::byte_t             cell_byte [MAX_PATTERN_BYTES+1];
  logic [MAX_PATTERN_BYTES:0] cell_valid;
  logic [MAX_PATTERN_BYTES-1:0] cell_hit;

  assign cell_byte[0]  = in_data_byte;
  assign cell_valid[0] = 1'b1;

  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
    logic [31:0]    k;
    logic           active;
    bpm_pkg::byte_t pb;

    // Window position i holds pattern byte len-1-i
    assign active = 32'(len) > 32'(i);
    assign k      = 32'(len) - 32'(1) - 32'(i);
    assign pb     = (k < 32'(bpm_pkg::PATTERN_REG_BYTES))
                  ? bpm_pkg::pat_byte({pat_high_r, pat_low_r}, k[3:0])
                  : 8'h00;

    bpm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .byte_in  (cell_byte[i]),
      .valid_in (cell_valid[i]),
      .pat_byte (pb),
      .active   (active),
      .byte_out (cell_byte[i+1]),
      .valid_out(cell_valid[i+1]),
      .hit      (cell_hit[i])
    );
  end

  assign hit    = scan && (&cell_hit);
  assign result = scan && (hit || in_last_of_file);

  // Result word for this cycle
  logic          res_found;
  logic [OW-1:0] res_offset;
  assign res_found  = hit;
  assign res_offset = hit ? (byte_offset_r - (OW'(len) - OW'(1))) : '0;

  // Offset counter saturates; match flag holds until the file ends
  always_comb begin
    byte_offset_nxt = byte_offset_r;
    match_done_nxt  = match_done_r;
    if (scan && (byte_offset_r != '1)) begin
      byte_offset_nxt = byte_offset_r + OW'(1);
    end
    if (hit) begin
      match_done_nxt = 1'b1;
    end
    if (restart) begin
      byte_offset_nxt = '0;
      match_done_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= '0;
      match_done_r  <= 1'b0;
    end else begin
      byte_offset_r <= byte_offset_nxt;
      match_done_r  <= match_done_nxt;
    end
  end

  // Output register plus skid entry
  logic          out_valid_r, out_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  logic          out_found_r, out_found_nxt;
  logic [OW-1:0] out_off_r, out_off_nxt;
  logic          skid_found_r, skid_found_nxt;
  logic [OW-1:0] skid_off_r, skid_off_nxt;
  logic          out_take;

  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_found_nxt  = out_found_r;
    out_off_nxt    = out_off_r;
    skid_found_nxt = skid_found_r;
    skid_off_nxt   = skid_off_r;
    if (skid_valid_r) begin
      // Input is stalled here, so only drain the skid entry
      if (out_take) begin
        out_found_nxt  = skid_found_r;
        out_off_nxt    = skid_off_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (result) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_found_nxt = res_found;
        out_off_nxt   = res_offset;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_found_nxt = res_found;
        skid_off_nxt   = res_offset;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r  <= out_found_nxt;
    out_off_r    <= out_off_nxt;
    skid_found_r <= skid_found_nxt;
    skid_off_r   <= skid_off_nxt;
  end

  assign in_stall         = skid_valid_r;
  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_start_offset = out_off_r;

endmodule

// ===== src/bpm_cell.sv =====
// One window cell: holds one byte and its fill flag, compares its incoming byte.
module bpm_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bpm_pkg::bpm_cell_ctl_t ctl,
  input  bpm_pkg::byte_t        byte_in,
  input  logic                  valid_in,
  input  bpm_pkg::byte_t        pat_byte,
  input  logic                  active,
  output bpm_pkg::byte_t        byte_out,
  output logic                  valid_out,
  output logic                  hit
);

  bpm_pkg::byte_t byte_r, byte_nxt;
  logic           valid_r, valid_nxt;

  // Compare the byte arriving this cycle; inactive cells always agree
  assign hit = !active || (valid_in && (byte_in == pat_byte));

  // Advance the byte on a shift, drop the fill flag on a restart
  always_comb begin
    byte_nxt  = byte_r;
    valid_nxt = valid_r;
    if (ctl.shift) begin
      byte_nxt  = byte_in;
      valid_nxt = valid_in;
    end
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_out  = byte_r;
  assign valid_out = valid_r;

endmodule

// ===== src/bpm_checker.sv =====
// Port-level checks for the byte pattern matcher, bound to the top level.
module bpm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_found,
  input logic [bpm_pkg::OFFSET_W-1:0] out_start_offset
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // A miss always reports offset zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_start_offset == '0)
    else $error("miss reported with non-zero offset");

  // Input stalls only while a result is held at the output
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // The skid entry fills only behind a stalled output word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall raised without output back-pressure");

endmodule

bind byte_pattern_matcher bpm_checker u_bpm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_found       (out_found),
  .out_start_offset(out_start_offset)
);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the byte pattern matcher: directed and random files.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN_BYTES    = bpm_pkg::MAX_PATTERN_BYTES_DEF;
  localparam int unsigned RANDOM_ITEMS = 1370;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct {
    logic                         found;
    logic [bpm_pkg::OFFSET_W-1:0] offset;
  } match_res_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     in_data_byte = 8'h00;
  logic                           in_last_of_file = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_found;
  logic [bpm_pkg::OFFSET_W-1:0]   out_start_offset;
  logic                           cfg_wr_en = 1'b0;
  logic [bpm_pkg::CFG_IDX_W-1:0]  cfg_index = bpm_pkg::REG_PATTERN_LOW;
  logic [bpm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of the configuration and the scan state
  logic [63:0]                  pat_lo = '0;
  logic [63:0]                  pat_hi = '0;
  logic [4:0]                   pat_len = 5'd1;
  bpm_pkg::byte_t               scan_win [WIN_BYTES] = '{default: 8'h00};
  logic [bpm_pkg::OFFSET_W-1:0] scan_ofs = '0;
  int unsigned                  scan_fill = 0;
  logic                         scan_done = 1'b0;
  int unsigned                  live_items = 0;

  match_res_t exp_results [$];
  match_res_t head;
  int unsigned errors = 0;
  int unsigned cycle_no = 0;
  int unsigned in_gap_pct = 31;
  int unsigned out_gap_pct = 31;
  int unsigned hold_len = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;

  byte_pattern_matcher uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_of_file  (in_last_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_start_offset (out_start_offset),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Count cycles and abandon a hung run
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stall the result channel: random gaps, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_gap_pct);
    end
  end

  // Compare every accepted result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (exp_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual found=%0b offset=%0d",
                 $time, out_found, out_start_offset);
        errors++;
      end else begin
        head = exp_results.pop_front();
        if (out_found !== head.found) begin
          $display("%0t: found mismatch, expected %0b, actual %0b",
                   $time, head.found, out_found);
          errors++;
        end
        if (out_start_offset !== head.offset) begin
          $display("%0t: start_offset mismatch, expected %0d, actual %0d",
                   $time, head.offset, out_start_offset);
          errors++;
        end
      end
    end
  end

  function automatic int unsigned eff_len();
    if (pat_len == 0) return 1;
    if (pat_len > WIN_BYTES) return WIN_BYTES;
    return pat_len;
  endfunction

  function automatic bpm_pkg::byte_t pat_at(input int unsigned k);
    if (k < 8) return pat_lo[8*k +: 8];
    return pat_hi[8*(k-8) +: 8];
  endfunction

  // Advance the predicted scan by one byte and queue any result it gives
  task automatic scan_byte(input bpm_pkg::byte_t d, input logic l);
    int unsigned                  n;
    logic [bpm_pkg::OFFSET_W-1:0] cur;
    logic                         hit;
    live_items++;
    if (!scan_done) begin
      for (int i = WIN_BYTES - 1; i > 0; i--) scan_win[i] = scan_win[i-1];
      scan_win[0] = d;
      if (scan_fill < WIN_BYTES) scan_fill++;
      cur = scan_ofs;
      if (scan_ofs != '1) scan_ofs++;
      n   = eff_len();
      hit = (scan_fill >= n);
      for (int k = 0; k < n; k++) begin
        if (scan_win[n-1-k] != pat_at(k)) hit = 1'b0;
      end
      if (hit) begin
        exp_results.push_back('{1'b1, cur - bpm_pkg::OFFSET_W'(n - 1)});
        scan_done = 1'b1;
      end else if (l) begin
        exp_results.push_back('{1'b0, '0});
      end
    end
    // restart for the next file
    if (l) begin
      foreach (scan_win[i]) scan_win[i] = 8'h00;
      scan_ofs  = '0;
      scan_fill = 0;
      scan_done = 1'b0;
    end
  endtask

  // Offer one byte, hold it until taken, then predict
  task automatic send_word(input bpm_pkg::byte_t d, input logic l);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= d;
    in_last_of_file <= l;
    do @(posedge clk); while (in_stall);
    scan_byte(d, l);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers back to back; call only when drained
  task automatic set_pattern(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] len);
    cfg_wr_en <= 1'b1;
    cfg_index <= bpm_pkg::REG_PATTERN_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    pat_lo = lo;
    cfg_index <= bpm_pkg::REG_PATTERN_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    pat_hi = hi;
    cfg_index <= bpm_pkg::REG_PATTERN_LENGTH;
    cfg_wdata <= bpm_pkg::CFG_DATA_W'(len);
    @(posedge clk);
    pat_len = len;
    cfg_wr_en <= 1'b0;
  endtask

  // Reset pattern is a single zero byte: a miss, then a hit on the last byte
  task automatic test_reset_values();
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b1);
  endtask

  // Length zero acts as one; length above the window acts as the full window
  task automatic test_length_bounds();
    drain();
    set_pattern(64'h0000_0000_0000_00AB, '1, 5'd0);
    send_word(8'h01, 1'b0);
    send_word(8'hAB, 1'b0);
    send_word(8'hAB, 1'b0);
    send_word(8'h7F, 1'b1);
    drain();
    set_pattern('0, '1, 5'd31);
    repeat (8) send_word(8'h00, 1'b0);
    repeat (7) send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b1);
  endtask

  // Change the pattern in mid-file; the window must be kept
  task automatic test_midfile_config();
    drain();
    set_pattern(64'h0000_0000_0000_0099, '0, 5'd1);
    send_word(8'h12, 1'b0);
    send_word(8'h34, 1'b0);
    drain();
    set_pattern(64'h0000_0000_0056_3412, '0, 5'd3);
    send_word(8'h56, 1'b1);
  endtask

  // Hold off the receiver while single-byte files keep coming, so input stalls
  task automatic test_result_hold_off();
    drain();
    set_pattern('1, '0, 5'd1);
    in_gap_pct = 0;
    hold_len   = 300;
    hold_req++;
    for (int i = 0; i < 40; i++) send_word((i % 3 == 2) ? 8'h00 : 8'hFF, 1'b1);
    drain();
    in_gap_pct = 31;
  endtask

  // Random files built around the pattern, with noise and cut-short copies
  task automatic test_random_files();
    bpm_pkg::byte_t alpha [3];
    bpm_pkg::byte_t file_bytes [$];
    logic [63:0]    lo;
    logic [63:0]    hi;
    logic [4:0]     len_cfg;
    int unsigned    start_items, files, flen, n, pos, cut, r;
    logic           noise;
    start_items = live_items;
    files       = 0;
    while (live_items - start_items < RANDOM_ITEMS) begin
      // new pattern from a small byte set every few files
      if (files % 4 == 0) begin
        alpha[0] = $urandom_range(1) ? 8'h00 : 8'($urandom);
        alpha[1] = 8'($urandom);
        alpha[2] = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
        for (int k = 0; k < 8; k++) begin
          lo[8*k +: 8] = ($urandom_range(99) < 85) ? alpha[$urandom_range(2)] : 8'($urandom);
          hi[8*k +: 8] = ($urandom_range(99) < 85) ? alpha[$urandom_range(2)] : 8'($urandom);
        end
        r = $urandom_range(99);
        if (r < 5) len_cfg = 5'd0;
        else if (r < 10) len_cfg = 5'($urandom_range(31, 17));
        else if (r < 20) len_cfg = 5'd16;
        else len_cfg = 5'($urandom_range(8, 1));
        drain();
        set_pattern(lo, hi, len_cfg);
      end
      // one long stretch with no idling on either side
      if (files >= 40 && files < 70) begin
        in_gap_pct  = 0;
        out_gap_pct = 0;
      end else begin
        in_gap_pct  = 31;
        out_gap_pct = 31;
      end
      flen  = ($urandom_range(9) == 0) ? $urandom_range(300, 40) : $urandom_range(24, 1);
      noise = ($urandom_range(4) == 0);
      file_bytes.delete();
      repeat (flen) begin
        file_bytes.push_back((noise || $urandom_range(2) == 0) ?
                             8'($urandom) : alpha[$urandom_range(2)]);
      end
      // plant the pattern, sometimes behind a broken lead-in
      if (!noise && $urandom_range(3) != 0) begin
        n   = eff_len();
        pos = $urandom_range(file_bytes.size());
        for (int k = n - 1; k >= 0; k--) file_bytes.insert(pos, pat_at(k));
        if ($urandom_range(3) == 0) begin
          cut = $urandom_range(n - 1);
          for (int k = cut - 1; k >= 0; k--) file_bytes.insert(pos, pat_at(k));
        end
      end
      foreach (file_bytes[i]) send_word(file_bytes[i], i == file_bytes.size() - 1);
      files++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_length_bounds();
    test_midfile_config();
    test_result_hold_off();
    test_random_files();
    drain();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
